// File: rtl/lz_sequence_parser_defines.svh
// assertion macros for the lz sequence parser
// used by files that assert; expects clk and rst_n in scope
`ifndef LZ_SEQUENCE_PARSER_DEFINES_SVH
`define LZ_SEQUENCE_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LZSP_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lz_sequence_parser: assertion failed");

// next-cycle implication, disabled while in reset
`define LZSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lz_sequence_parser: assertion failed");

`endif

// File: rtl/lzsp_pkg.sv
// shared types and constants for the lz sequence parser
// no dependencies
package lzsp_pkg;

    // result kinds
    localparam logic [1:0] KIND_LIT   = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // offset modes in token bits 7:6
    localparam logic [1:0] MODE_RECENT = 2'd0;
    localparam logic [1:0] MODE_OLDER  = 2'd1;
    localparam logic [1:0] MODE_OFF1   = 2'd2;
    localparam logic [1:0] MODE_OFF2   = 2'd3;

    localparam logic [2:0] FIELD_EXT      = 3'd7;
    localparam int         EXT_GROUP_W    = 7;
    localparam int         EXT_W          = 3 * EXT_GROUP_W;
    localparam logic [1:0] EXT_MAX_SEEN   = 2'd2;
    localparam int         LIT_EXT_BASE   = 7;
    localparam int         MATCH_MIN      = 4;
    localparam int         MATCH_EXT_BASE = 11;

    localparam logic [15:0] RECENT_RESET = 16'd1;
    localparam logic [15:0] OLDER_RESET  = 16'd4;

    localparam int QDEPTH  = 4;
    localparam int TDATA_W = 40;
    localparam int LEN_W   = 13;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       lit_byte;
        logic [15:0]      match_offset;
        logic [LEN_W-1:0] match_length;
        logic             run_end;
    } lzsp_result_t;

    // results of one parsed byte, in order
    typedef struct packed {
        logic [1:0]   count;
        lzsp_result_t first;
        lzsp_result_t second;
    } lzsp_step_t;

endpackage

// File: rtl/lz_sequence_parser.sv
// lz sequence parser: compressed page bytes in, literal and match commands out
// depends on lzsp_pkg, lzsp_parse_core and lz_sequence_parser_defines.svh
//
// usage:
//   s_* carries the compressed page, one byte per transfer, tlast on the page's
//   final byte. m_* carries results: tuser gives the kind (literal, match, page
//   done, error), tlast marks the last result that one input byte caused.
//   the history copy for matches is left to a downstream engine.
//   path: input register, then parse into a 4-entry result queue that drives m_*.
//   throughput: one byte per cycle while the queue can take two results, set by
//   the parse between the input register and the queue; output runs at one
//   result per cycle while m_tready is high, so a byte with two results (literal
//   plus match or end) costs one extra queue slot.
//   after a page error the bytes up to the next tlast are swallowed silently.
//   reset: parser returns to the start of a page, the queue empties.
//   stall: while the receiver holds m_tready low the queue fills; once it holds
//   more than two results the input register stops being drained and s_tready
//   falls when that register is occupied.
`include "lz_sequence_parser_defines.svh"

module lz_sequence_parser #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // in_byte
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lzsp_pkg::TDATA_W-1:0] m_tdata,   // lit_byte, match_offset, match_length, zero pad
    output logic [1:0]                   m_tuser,   // kind
    output logic                         m_tlast
);

    localparam int PTR_W = $clog2(lzsp_pkg::QDEPTH);
    localparam int CNT_W = $clog2(lzsp_pkg::QDEPTH + 1);
    localparam int USED_W = 8 + 16 + lzsp_pkg::LEN_W;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   step;
    logic                   pop;
    lzsp_pkg::lzsp_step_t   step_res;

    lzsp_pkg::lzsp_result_t q_reg [lzsp_pkg::QDEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       push_cnt;
    lzsp_pkg::lzsp_result_t head;

    // parse only when the queue can take two results
    assign step     = in_valid_reg && (count_reg <= CNT_W'(lzsp_pkg::QDEPTH - 2));
    assign s_tready = !in_valid_reg || step;
    assign pop      = m_tvalid && m_tready;
    assign push_cnt = step ? CNT_W'(step_res.count) : '0;

    lzsp_parse_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .data_last (in_last_reg),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign count_next = count_reg + push_cnt - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && step_res.count != 2'd0)
            q_reg[wr_ptr_reg] <= step_res.first;
        if (step && step_res.count == 2'd2)
            q_reg[wr_ptr_reg + PTR_W'(1)] <= step_res.second;
    end

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {(lzsp_pkg::TDATA_W - USED_W)'(0), head.match_length,
                       head.match_offset, head.lit_byte};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.run_end;

    `LZSP_ASSERT(a_queue_no_overflow, step, (4'(count_reg) + 4'(step_res.count)) <= 4'(lzsp_pkg::QDEPTH))
    `LZSP_ASSERT_NEXT(a_stalled_byte_held, in_valid_reg && !step, in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))
    `LZSP_ASSERT_NEXT(a_count_idle_stable, !step && !pop, $stable(count_reg))

endmodule

// File: rtl/lzsp_parse_core.sv
// parsing state and per-byte decode of the lz sequence parser
// depends on lzsp_pkg
module lzsp_parse_core #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               data_last,
    output lzsp_pkg::lzsp_step_t res
);

    localparam int POS_W = $clog2(PAGE_BYTES + 1);
    localparam int NL_W  = lzsp_pkg::EXT_W + 1;
    localparam int CMP_W = (NL_W > POS_W + 1) ? NL_W : POS_W + 1;
    localparam logic [CMP_W-1:0] PAGE_C = CMP_W'(PAGE_BYTES);

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_LIT_EXT,
        PH_LITERALS,
        PH_OFF_LO,
        PH_OFF_HI,
        PH_LEN_EXT
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  token_reg, token_next;
    logic [lzsp_pkg::EXT_W-1:0]  acc_reg, acc_next;
    logic [1:0]                  seen_reg, seen_next;
    logic [POS_W-1:0]            lit_left_reg, lit_left_next;
    logic [7:0]                  off_low_reg, off_low_next;
    logic [15:0]                 recent_reg, recent_next;
    logic [15:0]                 older_reg, older_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic                        discard_reg, discard_next;

    logic [lzsp_pkg::EXT_W-1:0]  acc_new;
    logic                        do_start, do_after, do_len, do_finish;
    logic [CMP_W-1:0]            nl, flen;
    logic                        has_lit, has_match, term_err, term_done;
    logic                        emit_match, emit_term;
    lzsp_pkg::lzsp_result_t      lit_res, match_res, term_res;

    always_comb
    begin
        case (seen_reg)
            2'd0:    acc_new = acc_reg | lzsp_pkg::EXT_W'(data_byte[6:0]);
            2'd1:    acc_new = acc_reg |
                               (lzsp_pkg::EXT_W'(data_byte[6:0]) << lzsp_pkg::EXT_GROUP_W);
            default: acc_new = acc_reg |
                               (lzsp_pkg::EXT_W'(data_byte[6:0]) << (2 * lzsp_pkg::EXT_GROUP_W));
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        token_next    = token_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        lit_left_next = lit_left_reg;
        off_low_next  = off_low_reg;
        recent_next   = recent_reg;
        older_next    = older_reg;
        pos_next      = pos_reg;
        discard_next  = discard_reg;
        do_start      = 1'b0;
        do_after      = 1'b0;
        do_len        = 1'b0;
        do_finish     = 1'b0;
        nl            = '0;
        flen          = '0;
        has_lit       = 1'b0;
        has_match     = 1'b0;
        term_err      = 1'b0;
        term_done     = 1'b0;

        if (discard_reg)
        begin
            // skip the rest of a failed page
            if (data_last)
                discard_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_TOKEN:
                begin
                    token_next = data_byte;
                    if (data_byte[2:0] == lzsp_pkg::FIELD_EXT)
                    begin
                        acc_next   = '0;
                        seen_next  = '0;
                        phase_next = PH_LIT_EXT;
                    end
                    else
                    begin
                        do_start = 1'b1;
                        nl       = CMP_W'(data_byte[2:0]);
                    end
                end
                PH_LIT_EXT:
                begin
                    acc_next = acc_new;
                    if (!data_byte[7])
                    begin
                        do_start = 1'b1;
                        nl       = CMP_W'(acc_new) + CMP_W'(lzsp_pkg::LIT_EXT_BASE);
                    end
                    else if (seen_reg >= lzsp_pkg::EXT_MAX_SEEN)
                        term_err = 1'b1;
                    else
                        seen_next = seen_reg + 2'd1;
                end
                PH_LITERALS:
                begin
                    has_lit       = 1'b1;
                    pos_next      = pos_reg + POS_W'(1);
                    lit_left_next = lit_left_reg - POS_W'(1);
                    if (lit_left_next == '0)
                        do_after = 1'b1;
                end
                PH_OFF_LO:
                begin
                    off_low_next = data_byte;
                    if (token_reg[7:6] == lzsp_pkg::MODE_OFF1)
                    begin
                        older_next  = recent_reg;
                        recent_next = 16'(data_byte) + 16'd1;
                        do_len      = 1'b1;
                    end
                    else
                        phase_next = PH_OFF_HI;
                end
                PH_OFF_HI:
                begin
                    older_next  = recent_reg;
                    recent_next = {data_byte, off_low_reg};
                    do_len      = 1'b1;
                end
                PH_LEN_EXT:
                begin
                    acc_next = acc_new;
                    if (!data_byte[7])
                    begin
                        do_finish = 1'b1;
                        flen      = CMP_W'(acc_new) + CMP_W'(lzsp_pkg::MATCH_EXT_BASE);
                    end
                    else if (seen_reg >= lzsp_pkg::EXT_MAX_SEEN)
                        term_err = 1'b1;
                    else
                        seen_next = seen_reg + 2'd1;
                end
                default:
                    term_err = 1'b1;
            endcase

            // literal run start: must fit in what is left of the page
            if (do_start)
            begin
                if (nl > PAGE_C - CMP_W'(pos_next))
                    term_err = 1'b1;
                else
                begin
                    lit_left_next = POS_W'(nl);
                    if (nl != '0)
                        phase_next = PH_LITERALS;
                    else
                        do_after = 1'b1;
                end
            end

            // literals finished: page end check, then offset selection
            if (do_after)
            begin
                if (CMP_W'(pos_next) >= PAGE_C)
                begin
                    if (data_last && token_next[7:3] == 5'd0)
                        term_done = 1'b1;
                    else
                        term_err = 1'b1;
                end
                else
                begin
                    case (token_next[7:6])
                        lzsp_pkg::MODE_RECENT:
                            do_len = 1'b1;
                        lzsp_pkg::MODE_OLDER:
                        begin
                            older_next  = recent_reg;
                            recent_next = older_reg;
                            do_len      = 1'b1;
                        end
                        default:
                            phase_next = PH_OFF_LO;
                    endcase
                end
            end

            if (do_len)
            begin
                if (token_next[5:3] == lzsp_pkg::FIELD_EXT)
                begin
                    acc_next   = '0;
                    seen_next  = '0;
                    phase_next = PH_LEN_EXT;
                end
                else
                begin
                    do_finish = 1'b1;
                    flen      = CMP_W'(token_next[5:3]) + CMP_W'(lzsp_pkg::MATCH_MIN);
                end
            end

            if (do_finish)
            begin
                if (recent_next == 16'd0 || CMP_W'(recent_next) > CMP_W'(pos_next) ||
                    flen > PAGE_C - CMP_W'(pos_next))
                    term_err = 1'b1;
                else
                begin
                    has_match  = 1'b1;
                    pos_next   = pos_next + POS_W'(flen);
                    phase_next = PH_TOKEN;
                end
            end

            // a last byte that does not close the page cleanly
            if (data_last && !term_done)
                term_err = 1'b1;

            if (term_err || term_done)
            begin
                phase_next    = PH_TOKEN;
                token_next    = '0;
                acc_next      = '0;
                seen_next     = '0;
                lit_left_next = '0;
                off_low_next  = '0;
                recent_next   = lzsp_pkg::RECENT_RESET;
                older_next    = lzsp_pkg::OLDER_RESET;
                pos_next      = '0;
                if (term_err && !data_last)
                    discard_next = 1'b1;
            end
        end
    end

    // result assembly: an error replaces a match from the same byte
    always_comb
    begin
        emit_match = has_match && !term_err;
        emit_term  = term_err || term_done;

        lit_res          = '0;
        lit_res.kind     = lzsp_pkg::KIND_LIT;
        lit_res.lit_byte = data_byte;

        match_res              = '0;
        match_res.kind         = lzsp_pkg::KIND_MATCH;
        match_res.match_offset = recent_next;
        match_res.match_length = lzsp_pkg::LEN_W'(flen);

        term_res      = '0;
        term_res.kind = term_err ? lzsp_pkg::KIND_ERR : lzsp_pkg::KIND_DONE;

        res = '0;
        if (has_lit)
        begin
            res.first = lit_res;
            if (emit_match)
                res.second = match_res;
            else if (emit_term)
                res.second = term_res;
        end
        else if (emit_match)
        begin
            res.first = match_res;
            if (emit_term)
                res.second = term_res;
        end
        else if (emit_term)
            res.first = term_res;

        res.count = 2'(has_lit) + 2'(emit_match) + 2'(emit_term);
        if (res.count == 2'd1)
            res.first.run_end = 1'b1;
        else if (res.count == 2'd2)
            res.second.run_end = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TOKEN;
            token_reg    <= '0;
            acc_reg      <= '0;
            seen_reg     <= '0;
            lit_left_reg <= '0;
            off_low_reg  <= '0;
            recent_reg   <= lzsp_pkg::RECENT_RESET;
            older_reg    <= lzsp_pkg::OLDER_RESET;
            pos_reg      <= '0;
            discard_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            token_reg    <= token_next;
            acc_reg      <= acc_next;
            seen_reg     <= seen_next;
            lit_left_reg <= lit_left_next;
            off_low_reg  <= off_low_next;
            recent_reg   <= recent_next;
            older_reg    <= older_next;
            pos_reg      <= pos_next;
            discard_reg  <= discard_next;
        end
    end

endmodule

// File: test/tb_lz_sequence_parser.sv
// testbench for lz_sequence_parser: directed and random compressed pages with a scoreboard
// depends on lzsp_pkg and the lz_sequence_parser rtl
`timescale 1ns / 1ps

module tb_lz_sequence_parser;

    localparam int PAGE_BYTES   = 4096;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    // positions of the result fields in m_tdata
    localparam int LIT_LSB      = 0;
    localparam int OFF_LSB      = 8;
    localparam int LEN_LSB      = 24;

    typedef enum logic [2:0] {
        P_TOKEN,
        P_LIT_EXT,
        P_LITERALS,
        P_OFF_LO,
        P_OFF_HI,
        P_LEN_EXT
    } parse_phase_t;

    typedef enum logic [1:0] {
        EXT_MORE,
        EXT_DONE,
        EXT_BAD
    } ext_status_t;

    class lz_page_scoreboard_t;
        parse_phase_t phase;
        logic [7:0]   token;
        int unsigned  ext_acc;
        int unsigned  ext_seen;
        int unsigned  lits_left;
        logic [7:0]   off_lo;
        logic [15:0]  recent_off;
        logic [15:0]  older_off;
        int unsigned  out_pos;
        bit           discarding;
        // what the byte being parsed produces
        bit           got_lit;
        bit           got_match;
        bit           ended;
        logic [1:0]   end_kind;
        logic [7:0]   lit_val;
        logic [15:0]  match_off;
        int unsigned  match_len;
        lzsp_pkg::lzsp_result_t expected_q[$];
        int           mismatches;
        int           parsed_bytes;

        function new();
            restart_page();
            discarding   = 1'b0;
            mismatches   = 0;
            parsed_bytes = 0;
        endfunction

        function void restart_page();
            phase      = P_TOKEN;
            token      = 8'd0;
            ext_acc    = 0;
            ext_seen   = 0;
            lits_left  = 0;
            off_lo     = 8'd0;
            recent_off = lzsp_pkg::RECENT_RESET;
            older_off  = lzsp_pkg::OLDER_RESET;
            out_pos    = 0;
        endfunction

        function void close_page(logic [1:0] kind);
            ended    = 1'b1;
            end_kind = kind;
        endfunction

        function ext_status_t ext_take(logic [7:0] b);
            ext_acc = ext_acc | (32'(b[6:0]) << (lzsp_pkg::EXT_GROUP_W * ext_seen));
            if (!b[7])
                return EXT_DONE;
            if (ext_seen >= lzsp_pkg::EXT_MAX_SEEN)
                return EXT_BAD;
            ext_seen++;
            return EXT_MORE;
        endfunction

        function void finish_match(int unsigned len);
            if (recent_off == 16'd0 || recent_off > out_pos || len > PAGE_BYTES - out_pos)
            begin
                close_page(lzsp_pkg::KIND_ERR);
                return;
            end
            got_match = 1'b1;
            match_off = recent_off;
            match_len = len;
            out_pos   = out_pos + len;
            phase     = P_TOKEN;
        endfunction

        function void set_offset(logic [1:0] mode, logic [15:0] off);
            if (mode != lzsp_pkg::MODE_RECENT)
                older_off = recent_off;
            recent_off = off;
        endfunction

        function void length_stage();
            if (token[5:3] == lzsp_pkg::FIELD_EXT)
            begin
                ext_acc  = 0;
                ext_seen = 0;
                phase    = P_LEN_EXT;
            end
            else
                finish_match(lzsp_pkg::MATCH_MIN + 32'(token[5:3]));
        endfunction

        function void after_literals(bit lst);
            logic [1:0] mode;
            mode = token[7:6];
            // a full page may only be closed by a bare token on the final byte
            if (out_pos >= PAGE_BYTES)
            begin
                close_page((lst && token[7:3] == 5'd0) ? lzsp_pkg::KIND_DONE
                                                       : lzsp_pkg::KIND_ERR);
                return;
            end
            if (mode == lzsp_pkg::MODE_OFF1 || mode == lzsp_pkg::MODE_OFF2)
                phase = P_OFF_LO;
            else
            begin
                set_offset(mode, (mode == lzsp_pkg::MODE_RECENT) ? recent_off : older_off);
                length_stage();
            end
        endfunction

        function void start_literals(int unsigned count, bit lst);
            if (count > PAGE_BYTES - out_pos)
            begin
                close_page(lzsp_pkg::KIND_ERR);
                return;
            end
            lits_left = count;
            if (count != 0)
                phase = P_LITERALS;
            else
                after_literals(lst);
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] lb, logic [15:0] off,
                                  int unsigned len);
            lzsp_pkg::lzsp_result_t r;
            r.kind         = kind;
            r.lit_byte     = lb;
            r.match_offset = off;
            r.match_length = lzsp_pkg::LEN_W'(len);
            r.run_end      = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic lst);
            ext_status_t st;
            int          n_before;
            if (discarding)
            begin
                if (lst)
                    discarding = 1'b0;
                return;
            end
            parsed_bytes++;
            got_lit   = 1'b0;
            got_match = 1'b0;
            ended     = 1'b0;
            end_kind  = lzsp_pkg::KIND_DONE;
            lit_val   = 8'd0;
            match_off = 16'd0;
            match_len = 0;

            case (phase)
                P_TOKEN:
                begin
                    token = b;
                    if (b[2:0] == lzsp_pkg::FIELD_EXT)
                    begin
                        ext_acc  = 0;
                        ext_seen = 0;
                        phase    = P_LIT_EXT;
                    end
                    else
                        start_literals(32'(b[2:0]), lst);
                end
                P_LIT_EXT:
                begin
                    st = ext_take(b);
                    if (st == EXT_BAD)
                        close_page(lzsp_pkg::KIND_ERR);
                    else if (st == EXT_DONE)
                        start_literals(lzsp_pkg::LIT_EXT_BASE + ext_acc, lst);
                end
                P_LITERALS:
                begin
                    got_lit = 1'b1;
                    lit_val = b;
                    out_pos++;
                    lits_left--;
                    if (lits_left == 0)
                        after_literals(lst);
                end
                P_OFF_LO:
                begin
                    off_lo = b;
                    if (token[7:6] == lzsp_pkg::MODE_OFF1)
                    begin
                        set_offset(lzsp_pkg::MODE_OFF1, 16'(b) + 16'd1);
                        length_stage();
                    end
                    else
                        phase = P_OFF_HI;
                end
                P_OFF_HI:
                begin
                    set_offset(lzsp_pkg::MODE_OFF2, {b, off_lo});
                    length_stage();
                end
                P_LEN_EXT:
                begin
                    st = ext_take(b);
                    if (st == EXT_BAD)
                        close_page(lzsp_pkg::KIND_ERR);
                    else if (st == EXT_DONE)
                        finish_match(lzsp_pkg::MATCH_EXT_BASE + ext_acc);
                end
                default:
                    close_page(lzsp_pkg::KIND_ERR);
            endcase

            // a page cut short by tlast
            if (!ended && lst)
                close_page(lzsp_pkg::KIND_ERR);

            n_before = expected_q.size();
            if (got_lit)
                push_result(lzsp_pkg::KIND_LIT, lit_val, 16'd0, 0);
            // an error on the completing byte replaces the match
            if (got_match && !(ended && end_kind == lzsp_pkg::KIND_ERR))
                push_result(lzsp_pkg::KIND_MATCH, 8'd0, match_off, match_len);
            if (ended)
            begin
                push_result(end_kind, 8'd0, 16'd0, 0);
                restart_page();
                if (end_kind == lzsp_pkg::KIND_ERR && !lst)
                    discarding = 1'b1;
            end
            if (expected_q.size() > n_before)
                expected_q[expected_q.size() - 1].run_end = 1'b1;
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [lzsp_pkg::TDATA_W-1:0] data,
                                   logic lst);
            lzsp_pkg::lzsp_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result expected none actual kind %0h data %h", $time, kind, data);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            check_field("kind", 16'(want.kind), 16'(kind));
            check_field("lit_byte", 16'(want.lit_byte), 16'(data[LIT_LSB +: 8]));
            check_field("match_offset", want.match_offset, data[OFF_LSB +: 16]);
            check_field("match_length", 16'(want.match_length),
                        16'(data[LEN_LSB +: lzsp_pkg::LEN_W]));
            check_field("run_end", 16'(want.run_end), 16'(lst));
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;   // in_byte
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lzsp_pkg::TDATA_W-1:0]  m_tdata;   // lit_byte, match_offset, match_length, zero pad
    logic [1:0]                    m_tuser;   // kind
    logic                          m_tlast;

    lz_page_scoreboard_t  board;
    logic [7:0]           page_bytes[$];
    int unsigned          burst_left = 0;
    int unsigned          hold_left  = 0;
    int unsigned          ready_left = 0;
    int unsigned          ready_pct  = 100;
    bit                   hold_req   = 1'b0;
    int unsigned          cycles     = 0;

    lz_sequence_parser #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: a long hold-off on request, otherwise stretches of varying readiness
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            if (ready_left == 0)
            begin
                ready_left = $urandom_range(5, 80);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 50;
                    default: ready_pct = 20;
                endcase
            end
            ready_left--;
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata, m_tlast);
    end

    // returns just after the accepting edge; the next caller idles or drives at the falling edge
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_byte(b, lst);
        burst_left--;
    endtask

    task automatic send_page(input int unsigned last_idx);
        for (int unsigned i = 0; i <= last_idx; i++)
            send_byte(page_bytes[i], i == last_idx);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(negedge clk);
    endtask

    // 7-bit groups, low group first, sometimes padded with zero groups
    task automatic push_ext(input int unsigned value);
        int unsigned nb;
        logic [7:0]  grp;
        nb = (value < 128) ? 1 : (value < 16384) ? 2 : 3;
        if ($urandom_range(0, 4) == 0)
            nb = $urandom_range(nb, 3);
        for (int unsigned i = 0; i < nb; i++)
        begin
            grp = 8'((value >> (7 * i)) & 127);
            if (i < nb - 1)
                grp[7] = 1'b1;
            page_bytes.push_back(grp);
        end
    endtask

    // a well-formed page that fills exactly and closes with a literal-only sequence
    task automatic build_page();
        int unsigned pos, rem, lits, pos_lit, cap, mlen, off;
        logic [15:0] rec, old, tmp;
        logic [1:0]  mode;
        logic [7:0]  tok;
        page_bytes.delete();
        pos = 0;
        rec = lzsp_pkg::RECENT_RESET;
        old = lzsp_pkg::OLDER_RESET;
        forever
        begin
            rem = PAGE_BYTES - pos;
            if (rem <= 20)
            begin
                if (rem <= 6)
                    page_bytes.push_back(8'(rem));
                else
                begin
                    page_bytes.push_back({5'd0, lzsp_pkg::FIELD_EXT});
                    push_ext(rem - lzsp_pkg::LIT_EXT_BASE);
                end
                repeat (rem) page_bytes.push_back(8'($urandom_range(0, 255)));
                break;
            end
            if ($urandom_range(0, 2) != 0)
                lits = $urandom_range((pos == 0) ? 1 : 0, 6);
            else
                lits = lzsp_pkg::LIT_EXT_BASE + $urandom_range(0, 24);
            if (lits > rem - lzsp_pkg::MATCH_MIN)
                lits = rem - lzsp_pkg::MATCH_MIN;
            pos_lit = pos + lits;
            cap = PAGE_BYTES - pos_lit;
            case ((cap < lzsp_pkg::MATCH_EXT_BASE) ? 0 : $urandom_range(0, 3))
                0: mlen = $urandom_range(lzsp_pkg::MATCH_MIN, (cap < 10) ? cap : 10);
                1: mlen = $urandom_range(lzsp_pkg::MATCH_EXT_BASE, (cap < 138) ? cap : 138);
                default: mlen = $urandom_range(lzsp_pkg::MATCH_EXT_BASE, cap);
            endcase
            mode = 2'($urandom_range(0, 3));
            if ((mode == lzsp_pkg::MODE_RECENT && rec > pos_lit) ||
                (mode == lzsp_pkg::MODE_OLDER && old > pos_lit))
                mode = lzsp_pkg::MODE_OFF2;
            tok = {mode,
                   (mlen >= lzsp_pkg::MATCH_EXT_BASE) ? lzsp_pkg::FIELD_EXT
                                                      : 3'(mlen - lzsp_pkg::MATCH_MIN),
                   (lits >= lzsp_pkg::LIT_EXT_BASE) ? lzsp_pkg::FIELD_EXT : 3'(lits)};
            page_bytes.push_back(tok);
            if (lits >= lzsp_pkg::LIT_EXT_BASE)
                push_ext(lits - lzsp_pkg::LIT_EXT_BASE);
            repeat (lits) page_bytes.push_back(8'($urandom_range(0, 255)));
            case (mode)
                lzsp_pkg::MODE_OLDER:
                begin
                    tmp = rec;
                    rec = old;
                    old = tmp;
                end
                lzsp_pkg::MODE_OFF1:
                begin
                    off = $urandom_range(1, (pos_lit < 256) ? pos_lit : 256);
                    page_bytes.push_back(8'(off - 1));
                    old = rec;
                    rec = 16'(off);
                end
                lzsp_pkg::MODE_OFF2:
                begin
                    if ($urandom_range(0, 1) == 0)
                        off = $urandom_range(1, (pos_lit < 16) ? pos_lit : 16);
                    else
                        off = $urandom_range(1, pos_lit);
                    page_bytes.push_back(8'(off));
                    page_bytes.push_back(8'(off >> 8));
                    old = rec;
                    rec = 16'(off);
                end
                default:
                    ;
            endcase
            if (mlen >= lzsp_pkg::MATCH_EXT_BASE)
                push_ext(mlen - lzsp_pkg::MATCH_EXT_BASE);
            pos = pos_lit + mlen;
        end
    endtask

    initial
    begin
        int unsigned seg, fault, cut, n, start_bytes;
        board    = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // page filled by one literal and a long match, closed by a bare token
        page_bytes = '{8'h39, 8'hAB, 8'hF4, 8'h1F, 8'h00};
        send_page(4);
        // match from recent offset at position zero, rest of page swallowed
        page_bytes = '{8'h00, 8'hFF};
        send_page(1);
        // extension with a third continuation byte
        page_bytes = '{8'h07, 8'h80, 8'h80, 8'h80};
        send_page(3);
        // literal count beyond the page
        page_bytes = '{8'h07, 8'hFF, 8'hFF, 8'h7F};
        send_page(3);
        // literal then a failing older-offset match on the same byte
        page_bytes = '{8'h41, 8'h00};
        send_page(1);
        // two-byte offset of zero
        page_bytes = '{8'hC0, 8'h00, 8'h00};
        send_page(2);
        // full page followed by a token that still carries a match length
        page_bytes = '{8'h39, 8'hAB, 8'hF4, 8'h1F, 8'h08};
        send_page(4);
        // one-byte offset, then a match length beyond the page
        page_bytes = '{8'hBA, 8'h01, 8'h02, 8'h00, 8'hFF, 8'h7F};
        send_page(5);
        // literal with match, then a match completed on a truncating byte
        page_bytes = '{8'h01, 8'h11, 8'h00};
        send_page(2);
        wait_drained();

        start_bytes = board.parsed_bytes;
        seg = 0;
        while (board.parsed_bytes - start_bytes < RANDOM_ITEMS)
        begin
            if (seg == 2 || seg == 9)
                hold_req = 1'b1;
            if (seg % 6 == 5)
                wait_drained();
            fault = $urandom_range(0, 9);
            if (fault == 9)
            begin
                n = $urandom_range(1, 30);
                for (int unsigned i = 0; i < n; i++)
                    send_byte(8'($urandom_range(0, 255)),
                              (i == n - 1) || ($urandom_range(0, 5) == 0));
            end
            else
            begin
                build_page();
                cut = page_bytes.size() - 1;
                if (fault == 7)
                    cut = $urandom_range(0, cut - 1);
                else if (fault == 8)
                    page_bytes[$urandom_range(0, cut)] = 8'($urandom_range(0, 255));
                send_page(cut);
            end
            seg++;
        end

        wait_drained();
        repeat (16) @(negedge clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
